// ===== rtl/tmas_pkg.sv =====
// ----------------------------------------------------------------------------
// tmas_pkg
// Shared widths, types, state codes and saturation helpers of the trajectory
// moving-average smoother.
// ----------------------------------------------------------------------------
package tmas_pkg;

    localparam int DW    = 24;   // step and result width
    localparam int TW    = 40;   // trajectory width
    localparam int SW    = 48;   // window sum width
    localparam int FW    = 8;    // frame count width
    localparam int CFGW  = 6;    // radius register width
    localparam int RES_W = 51;   // corrected step before saturation

    localparam int MAX_RADIUS_DEF = 32;
    localparam int RING_DEPTH_DEF = 128;
    localparam logic [CFGW-1:0] RADIUS_RESET = CFGW'(15);

    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [TW-1:0] path_t;
    typedef logic signed [SW-1:0] sum_t;

    typedef struct packed {
        path_t  px;
        path_t  py;
        path_t  pa;
        delta_t dx;
        delta_t dy;
        delta_t da;
    } tmas_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIX,
        ST_OUT
    } tmas_state_t;

    function automatic path_t sat_path(input logic signed [TW:0] v);
        path_t r;
        if (v[TW] != v[TW-1])
            r = v[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        else
            r = v[TW-1:0];
        return r;
    endfunction

    function automatic sum_t sat_sum(input logic signed [SW:0] v);
        sum_t r;
        if (v[SW] != v[SW-1])
            r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            r = v[SW-1:0];
        return r;
    endfunction

    function automatic delta_t sat_delta(input logic signed [RES_W-1:0] v);
        delta_t r;
        if (v > 51'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -51'sd8388608)
            r = 24'sh800000;
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/tmas_if.sv =====
// ----------------------------------------------------------------------------
// tmas_if
// Valid/ready channels of the smoother: frame steps in, corrected steps out.
// ----------------------------------------------------------------------------
interface tmas_frame_if import tmas_pkg::*; ();
    logic   valid;
    logic   ready;
    delta_t delta_x;
    delta_t delta_y;
    delta_t delta_angle;
    logic   last_in;

    modport source (output valid, delta_x, delta_y, delta_angle, last_in, input ready);
    modport sink   (input valid, delta_x, delta_y, delta_angle, last_in, output ready);
endinterface

interface tmas_result_if import tmas_pkg::*; ();
    logic   valid;
    logic   ready;
    delta_t smooth_dx;
    delta_t smooth_dy;
    delta_t smooth_da;
    logic   last_out;

    modport source (output valid, smooth_dx, smooth_dy, smooth_da, last_out, input ready);
    modport sink   (input valid, smooth_dx, smooth_dy, smooth_da, last_out, output ready);
endinterface

// ===== rtl/tmas_ring.sv =====
// ----------------------------------------------------------------------------
// tmas_ring
// Ring memory of trajectory points and steps, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module tmas_ring import tmas_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tmas_entry_t   wr_data,
    input  logic [AW-1:0] rd_addr,
    output tmas_entry_t   rd_data
);

    tmas_entry_t mem [RING_DEPTH];
    tmas_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tmas_div.sv =====
// ----------------------------------------------------------------------------
// tmas_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module tmas_div import tmas_pkg::*; #(
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SW-1:0]    num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [SW-1:0]    quot
);

    localparam int CNTW = $clog2(SW);

    logic             busy_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [SW-1:0]    num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[SW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(SW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SW-2:0], ge};
            rem_reg <= rem_sub[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

// ===== rtl/trajectory_moving_average_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// trajectory_moving_average_smoother_unit
// Cumulative trajectory, centered moving average with edge truncation, and
// corrected frame steps, computed by a small sequencer over one ring memory
// and one shared divider.
//
//   channel   dir   payload                                      handshake
//   frame     in    delta_x, delta_y, delta_angle, last_in       valid/ready
//   result    out   smooth_dx, smooth_dy, smooth_da, last_out    valid/ready
//   cfg       in    cfg_wr_data (window radius)                  cfg_wr_en
//
// a frame that yields no result leaves the sequencer idle; each result runs
// a setup state, a ring walk over the frames of its window for the sums,
// per channel a divide of the 48-bit sum by the frame count and a fix-up,
// and an output state
// a last frame emits up to radius + 1 results, one after another
// frame.ready is high only while the sequencer is idle; a held result beat
// stalls the sequencer before the next result is loaded.
// reset clears all sequence state and sets the radius register to 15.
// ----------------------------------------------------------------------------
module trajectory_moving_average_smoother_unit import tmas_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    tmas_frame_if.sink      frame,
    tmas_result_if.source   result,
    input  logic            cfg_wr_en,
    input  logic [CFGW-1:0] cfg_wr_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int CW = $clog2(2 * MAX_RADIUS + 2);

    tmas_state_t state_reg, state_next;

    logic [CFGW-1:0] cfg_reg;
    path_t           run_reg  [3];
    path_t           run_next [3];
    logic [FW-1:0]   frames_reg, frames_next;
    logic [AW-1:0]   wr_slot_reg, wr_slot_next;
    logic [RW-1:0]   seq_r_reg, seq_r_next;

    logic [AW-1:0]   cur_reg, cur_next;
    logic [FW-1:0]   c_reg, c_next;
    logic [RW-1:0]   r_reg, r_next;
    logic            last_reg, last_next;
    logic [FW-1:0]   k_reg, k_next;
    logic [FW-1:0]   k_hi_reg, k_hi_next;
    logic [RW-1:0]   back_reg, back_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [1:0]      ch_reg, ch_next;
    sum_t            sum_reg  [3];
    sum_t            sum_next [3];
    delta_t          step_reg  [3];
    delta_t          step_next [3];
    path_t           path_reg  [3];
    path_t           path_next [3];
    delta_t          res_reg  [3];
    delta_t          res_next [3];

    logic            out_valid_reg, out_valid_next;
    delta_t          out_dx_reg, out_dy_reg, out_da_reg;
    delta_t          out_dx_next, out_dy_next, out_da_next;
    logic            out_last_reg, out_last_next;

    // accept-side values
    logic            accept;
    logic [RW-1:0]   cfg_clamped;
    logic [RW-1:0]   radius;
    delta_t          din [3];
    path_t           run_new [3];
    logic            emits;
    logic [FW-1:0]   k_lo;

    // ring and divider hookup
    logic            mem_wr_en;
    tmas_entry_t     mem_wr_data;
    logic [AW-1:0]   mem_rd_addr;
    tmas_entry_t     mem_rd_data;
    path_t           rd_path [3];
    delta_t          rd_step [3];
    logic            div_start;
    logic            div_busy;
    logic [SW-1:0]   div_num;
    logic [SW-1:0]   div_quot;

    logic            sum_neg;
    logic [SW-1:0]   sum_mag;
    logic signed [SW:0]      avg;
    logic signed [RES_W-1:0] res_wide;
    logic            load_out;

    tmas_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_slot_reg),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tmas_div #(.DEN_W(CW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cnt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_comb
    begin
        accept      = frame.valid && (state_reg == ST_IDLE);
        cfg_clamped = (cfg_reg > CFGW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(cfg_reg);
        radius      = (frames_reg == '0) ? cfg_clamped : seq_r_reg;
        din[0]      = frame.delta_x;
        din[1]      = frame.delta_y;
        din[2]      = frame.delta_angle;
        for (int i = 0; i < 3; i++)
        begin
            run_new[i] = sat_path((TW+1)'(run_reg[i]) + (TW+1)'(din[i]));
        end
        emits = frame.last_in || (frames_reg >= FW'(radius));
        k_lo  = (frames_reg >= FW'(radius)) ? (frames_reg - FW'(radius)) : '0;

        mem_wr_data = '{px: run_new[0], py: run_new[1], pa: run_new[2],
                        dx: din[0], dy: din[1], da: din[2]};
        rd_path[0] = mem_rd_data.px;
        rd_path[1] = mem_rd_data.py;
        rd_path[2] = mem_rd_data.pa;
        rd_step[0] = mem_rd_data.dx;
        rd_step[1] = mem_rd_data.dy;
        rd_step[2] = mem_rd_data.da;

        sum_neg  = sum_reg[ch_reg][SW-1];
        sum_mag  = sum_neg ? (SW'(0) - sum_reg[ch_reg]) : sum_reg[ch_reg];
        div_num  = sum_mag + SW'(cnt_reg >> 1);
        avg      = sum_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        res_wide = RES_W'(step_reg[ch_reg]) + RES_W'(avg) - RES_W'(path_reg[ch_reg]);
        load_out = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && emits)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (j_reg == cnt_reg)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!div_busy)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = (ch_reg == 2'd2) ? ST_OUT : ST_DIV_GO;
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = (k_reg == k_hi_reg) ? ST_IDLE : ST_SETUP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        frame.ready = (state_reg == ST_IDLE);
        mem_wr_en   = accept;
        mem_rd_addr = ptr_reg;
        div_start   = (state_reg == ST_DIV_GO);
    end

    // datapath
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            run_next[i]  = run_reg[i];
            sum_next[i]  = sum_reg[i];
            step_next[i] = step_reg[i];
            path_next[i] = path_reg[i];
            res_next[i]  = res_reg[i];
        end
        frames_next    = frames_reg;
        wr_slot_next   = wr_slot_reg;
        seq_r_next     = seq_r_reg;
        cur_next       = cur_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        k_hi_next      = k_hi_reg;
        back_next      = back_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        ptr_next       = ptr_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_dx_next    = out_dx_reg;
        out_dy_next    = out_dy_reg;
        out_da_next    = out_da_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next  = wr_slot_reg;
                    c_next    = frames_reg;
                    r_next    = radius;
                    last_next = frame.last_in;
                    k_next    = k_lo;
                    k_hi_next = frame.last_in ? frames_reg : k_lo;
                    if (frame.last_in)
                    begin
                        for (int i = 0; i < 3; i++)
                            run_next[i] = '0;
                        frames_next  = '0;
                        wr_slot_next = '0;
                        seq_r_next   = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            run_next[i] = run_new[i];
                        frames_next  = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
                        wr_slot_next = (wr_slot_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                            : wr_slot_reg + 1'b1;
                        seq_r_next   = radius;
                    end
                end
            end
            ST_SETUP:
            begin
                back_next = RW'(c_reg - k_reg);
                cnt_next  = CW'(RW'(c_reg - k_reg))
                          + CW'((k_reg < FW'(r_reg)) ? RW'(k_reg) : r_reg) + CW'(1);
                j_next    = '0;
                ptr_next  = cur_reg;
                for (int i = 0; i < 3; i++)
                    sum_next[i] = '0;
            end
            ST_SUM:
            begin
                if (j_reg != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        sum_next[i] = sat_sum((SW+1)'(sum_reg[i]) + (SW+1)'(rd_path[i]));
                    if (j_reg == CW'(back_reg) + CW'(1))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            step_next[i] = rd_step[i];
                            path_next[i] = rd_path[i];
                        end
                    end
                end
                if (j_reg != cnt_reg)
                    ptr_next = (ptr_reg == '0) ? AW'(RING_DEPTH - 1) : ptr_reg - 1'b1;
                j_next  = j_reg + 1'b1;
                ch_next = '0;
            end
            ST_DIV_GO, ST_DIV_WAIT:
            begin
            end
            ST_FIX:
            begin
                res_next[ch_reg] = sat_delta(res_wide);
                ch_next          = ch_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_dx_next    = res_reg[0];
                    out_dy_next    = res_reg[1];
                    out_da_next    = res_reg[2];
                    out_last_next  = last_reg && (k_reg == c_reg);
                    k_next         = k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= RADIUS_RESET;
            frames_reg    <= '0;
            wr_slot_reg   <= '0;
            seq_r_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                run_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            wr_slot_reg   <= wr_slot_next;
            seq_r_reg     <= seq_r_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
                run_reg[i] <= run_next[i];
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        c_reg        <= c_next;
        r_reg        <= r_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        k_hi_reg     <= k_hi_next;
        back_reg     <= back_next;
        cnt_reg      <= cnt_next;
        j_reg        <= j_next;
        ptr_reg      <= ptr_next;
        ch_reg       <= ch_next;
        out_dx_reg   <= out_dx_next;
        out_dy_reg   <= out_dy_next;
        out_da_reg   <= out_da_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < 3; i++)
        begin
            sum_reg[i]  <= sum_next[i];
            step_reg[i] <= step_next[i];
            path_reg[i] <= path_next[i];
            res_reg[i]  <= res_next[i];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.smooth_dx = out_dx_reg;
    assign result.smooth_dy = out_dy_reg;
    assign result.smooth_da = out_da_reg;
    assign result.last_out  = out_last_reg;

`ifndef SYNTHESIS
    // window walk never runs past its count
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> j_reg <= cnt_reg)
        else $error("window walk overran its count");

    // emitted frame lies within the radius behind the newest frame
    a_setup_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |-> (k_reg <= c_reg) && ((c_reg - k_reg) <= FW'(r_reg)))
        else $error("emitted frame outside window");

    // divider never starts on an empty window
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> cnt_reg != '0)
        else $error("divider started with zero count");

    // a result beat is loaded only after all three channels are fixed up
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT) |-> $past(state_reg == ST_FIX) && ch_reg == 2'd3)
        else $error("result loaded before all channels done");
`endif

endmodule
